[rtl/core/pcc_pkg.sv]
// shared types and constants for the point curvature classifier
`timescale 1ns / 1ps

package pcc_pkg;

    localparam int MAX_NEIGHBORS = 8;
    localparam int COORD_W       = 20;
    localparam int WIN_DEPTH     = 2 * MAX_NEIGHBORS + 1;
    localparam int IDX_W         = $clog2(WIN_DEPTH);
    localparam int K_W           = 4;
    localparam int SEEN_W        = $clog2(2 * MAX_NEIGHBORS + 1);
    localparam int LIM_W         = 40;
    localparam int HALF_W        = LIM_W / 2;
    localparam int K2_W          = 7;
    localparam int LIMS_W        = LIM_W + 6;
    localparam int SUM_W         = COORD_W + IDX_W;
    localparam int DIFF_W        = SUM_W + 1;
    localparam int MUL_W         = DIFF_W + 1;
    localparam int PROD_W        = 2 * MUL_W;
    localparam int DIST_W        = PROD_W;
    localparam int TDATA_W       = 64;
    localparam int CFG_IDX_W     = 2;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    typedef struct packed {
        logic             shift;
        logic [IDX_W-1:0] rd_idx;
    } win_ctl_t;

    typedef enum logic [1:0] {
        CLS_EDGE    = 2'd0,
        CLS_FLAT    = 2'd1,
        CLS_NEITHER = 2'd2
    } class_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_CALC,
        ST_EMIT
    } state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEIGHBOR_COUNT = 2'd0,
        REG_EDGE_LIMIT     = 2'd1,
        REG_FLAT_LIMIT     = 2'd2
    } cfg_reg_t;

    // step of the shared multiplier sequence: group selects axis or limit
    typedef enum logic [1:0] {
        PH_MUL_A = 2'd0,
        PH_LATCH = 2'd1,
        PH_MUL_B = 2'd2,
        PH_ACC   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        GRP_X    = 3'd0,
        GRP_Y    = 3'd1,
        GRP_Z    = 3'd2,
        GRP_EDGE = 3'd3,
        GRP_FLAT = 3'd4
    } group_t;

endpackage

[rtl/core/pcc_window.sv]
// point window shift register with a single read tap
`timescale 1ns / 1ps

module pcc_window import pcc_pkg::*; (
    input  logic     aclk,
    input  win_ctl_t win_ctl,
    input  point_t   wr_pt,
    output point_t   rd_pt
);

    point_t win_reg [WIN_DEPTH];

    always_ff @(posedge aclk) begin
        if (win_ctl.shift) begin
            win_reg[0] <= wr_pt;
            for (int i = 1; i < WIN_DEPTH; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    assign rd_pt = win_reg[win_ctl.rd_idx];

endmodule

[rtl/core/point_curvature_classifier.sv]
// point curvature classifier top level: sequencer, shared multiplier, output register
`timescale 1ns / 1ps

// channel  | dir | handshake          | payload
// s_       | in  | s_tvalid/s_tready  | s_tdata {z,y,x}, s_tlast scan end
// m_       | out | m_tvalid/m_tready  | m_tdata {z,y,x}, m_tuser class, m_tlast final of scan
// cfg_     | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// sequence: with K > 0 a point is accepted, the window is summed through its single read
// tap, then the shared 27x27 multiplier works through 3 axes and 2 limit scalings, 4 steps
// each, then results leave one per cycle while m_tready does not hold the output register;
// with K = 0 the accepted point goes straight to emit
// reset: synchronous on aresetn low, clears the sequencer, scan count, output valid
// and loads the register defaults; window contents are undefined until written
// stalls: m_tready low holds the result register; s_tready is high only when idle

module point_curvature_classifier import pcc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input points
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // [19:0] pos_x, [39:20] pos_y, [59:40] pos_z
    input  logic                 s_tlast,   // scan_end
    // classified points
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // [19:0] out_x, [39:20] out_y, [59:40] out_z
    output logic [1:0]           m_tuser,   // [1:0] point_class
    output logic                 m_tlast,   // final_of_scan
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LIM_W-1:0]     cfg_data
);

    // config registers
    logic [K_W-1:0]   nc_reg;
    logic [LIM_W-1:0] edge_lim_reg;
    logic [LIM_W-1:0] flat_lim_reg;

    // sequencer
    state_t state_reg, state_next;
    group_t grp_reg;
    phase_t ph_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] n_reg;
    logic [K_W-1:0]    k_reg;
    logic [K2_W-1:0]   k2_reg;
    logic              last_reg;
    logic              main_pend_reg;
    logic              fl_pend_reg;
    logic [K_W-1:0]    j_reg;

    // datapath
    logic signed [SUM_W-1:0]  sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [DIFF_W-1:0]        dabs_reg;
    logic [DIST_W-1:0]        dist_reg;
    logic [LIMS_W-1:0]        lim_e_reg, lim_f_reg;

    // output register
    logic   m_valid_reg;
    point_t m_pt_reg;
    class_t m_cls_reg;
    logic   m_last_reg;

    // comb
    logic                     s_acc;
    logic                     out_load;
    win_ctl_t                 win_ctl;
    point_t                   rd_pt;
    logic [K_W-1:0]           k_sat;
    logic [K_W-1:0]           top_j;
    logic signed [COORD_W-1:0] c_axis;
    logic signed [SUM_W-1:0]  s_axis;
    logic [LIM_W-1:0]         lim_src;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        diff_abs;
    logic                     is_axis;
    logic                     do_dist;
    class_t                   cls_main;
    class_t                   cls_flush;

    function automatic class_t class_of(input logic [DIST_W-1:0] score,
                                        input logic [LIMS_W-1:0] le,
                                        input logic [LIMS_W-1:0] lf);
        class_t c;
        if (score >= DIST_W'({le, 2'b00})) begin
            c = CLS_EDGE;
        end else if (score <= DIST_W'({lf, 2'b00})) begin
            c = CLS_FLAT;
        end else begin
            c = CLS_NEITHER;
        end
        return c;
    endfunction

    pcc_window u_window (
        .aclk    (aclk),
        .win_ctl (win_ctl),
        .wr_pt   (point_t'(s_tdata[3*COORD_W-1:0])),
        .rd_pt   (rd_pt)
    );

    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid & s_tready;

    // neighbor count above MAX_NEIGHBORS saturates
    assign k_sat = (nc_reg > K_W'(MAX_NEIGHBORS)) ? K_W'(MAX_NEIGHBORS) : nc_reg;
    assign top_j = (seen_reg < SEEN_W'(k_sat - 1'b1)) ? K_W'(seen_reg) : K_W'(k_sat - 1'b1);

    // axis / limit operand selection
    assign is_axis = (grp_reg == GRP_X) || (grp_reg == GRP_Y) || (grp_reg == GRP_Z);

    always_comb begin
        case (grp_reg)
            GRP_Y: begin
                c_axis = rd_pt.y;
                s_axis = sum_y_reg;
            end
            GRP_Z: begin
                c_axis = rd_pt.z;
                s_axis = sum_z_reg;
            end
            default: begin
                c_axis = rd_pt.x;
                s_axis = sum_x_reg;
            end
        endcase
        lim_src = (grp_reg == GRP_FLAT) ? flat_lim_reg : edge_lim_reg;
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ph_reg)
            PH_MUL_A: begin
                if (is_axis) begin
                    // (2K+1) * center, the center is also inside the window sum
                    mul_a = MUL_W'(c_axis);
                    mul_b = MUL_W'({k_reg, 1'b1});
                end else begin
                    mul_a = MUL_W'(lim_src[HALF_W-1:0]);
                    mul_b = MUL_W'(k2_reg);
                end
            end
            PH_MUL_B: begin
                if (is_axis) begin
                    mul_a = MUL_W'(dabs_reg);
                    mul_b = MUL_W'(dabs_reg);
                end else begin
                    mul_a = MUL_W'(lim_src[LIM_W-1:HALF_W]);
                    mul_b = MUL_W'(k2_reg);
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign diff     = DIFF_W'(s_axis) - signed'(prod_reg[DIFF_W-1:0]);
    assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    // score only counts with a full window on both sides
    assign do_dist   = n_reg >= SEEN_W'({k_reg, 1'b0});
    assign cls_flush = class_of('0, lim_e_reg, lim_f_reg);
    assign cls_main  = (k_reg == '0) ? CLS_NEITHER
                     : class_of(do_dist ? dist_reg : '0, lim_e_reg, lim_f_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = (k_sat == '0) ? ST_EMIT : ST_SUM;
                end
            end
            ST_SUM: begin
                if (idx_reg == IDX_W'({k_reg, 1'b0})) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (grp_reg == GRP_FLAT && ph_reg == PH_ACC) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!main_pend_reg && !fl_pend_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready       = 1'b0;
        out_load       = 1'b0;
        win_ctl.shift  = s_acc;
        win_ctl.rd_idx = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_SUM: begin
                win_ctl.rd_idx = idx_reg;
            end
            ST_CALC: begin
                win_ctl.rd_idx = IDX_W'(k_reg);
            end
            ST_EMIT: begin
                win_ctl.rd_idx = main_pend_reg ? IDX_W'(k_reg) : IDX_W'(j_reg);
                out_load = (main_pend_reg || fl_pend_reg) && (!m_valid_reg || m_tready);
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            seen_reg      <= '0;
            main_pend_reg <= 1'b0;
            fl_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            nc_reg        <= K_W'(5);
            edge_lim_reg  <= LIM_W'(52429);
            flat_lim_reg  <= LIM_W'(5243);
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_NEIGHBOR_COUNT: nc_reg       <= cfg_data[K_W-1:0];
                    REG_EDGE_LIMIT:     edge_lim_reg <= cfg_data;
                    REG_FLAT_LIMIT:     flat_lim_reg <= cfg_data;
                    default:            ;
                endcase
            end

            if (s_acc) begin
                // K = 0 gives one pass-through result, otherwise the center at lag K
                main_pend_reg <= (k_sat == '0) || (seen_reg >= SEEN_W'(k_sat));
                fl_pend_reg   <= s_tlast && (k_sat != '0);
                if (s_tlast) begin
                    seen_reg <= '0;
                end else if (seen_reg < SEEN_W'(2 * MAX_NEIGHBORS)) begin
                    seen_reg <= seen_reg + 1'b1;
                end
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
                if (main_pend_reg) begin
                    main_pend_reg <= 1'b0;
                end else if (j_reg == '0) begin
                    fl_pend_reg <= 1'b0;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            k_reg     <= k_sat;
            k2_reg    <= K2_W'(k_sat * k_sat);
            n_reg     <= seen_reg;
            last_reg  <= s_tlast;
            j_reg     <= top_j;
            idx_reg   <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
            dist_reg  <= '0;
            grp_reg   <= GRP_X;
            ph_reg    <= PH_MUL_A;
        end

        if (state_reg == ST_SUM) begin
            sum_x_reg <= sum_x_reg + SUM_W'(rd_pt.x);
            sum_y_reg <= sum_y_reg + SUM_W'(rd_pt.y);
            sum_z_reg <= sum_z_reg + SUM_W'(rd_pt.z);
            idx_reg   <= idx_reg + 1'b1;
        end

        if (state_reg == ST_CALC) begin
            case (ph_reg)
                PH_MUL_A, PH_MUL_B: begin
                    prod_reg <= mul_p;
                end
                PH_LATCH: begin
                    if (is_axis) begin
                        dabs_reg <= diff_abs;
                    end else if (grp_reg == GRP_EDGE) begin
                        lim_e_reg <= LIMS_W'(prod_reg[LIMS_W-1:0]);
                    end else begin
                        lim_f_reg <= LIMS_W'(prod_reg[LIMS_W-1:0]);
                    end
                end
                default: begin
                    if (is_axis) begin
                        dist_reg <= dist_reg + DIST_W'(unsigned'(prod_reg));
                    end else if (grp_reg == GRP_EDGE) begin
                        lim_e_reg <= lim_e_reg + {prod_reg[LIMS_W-HALF_W-1:0], HALF_W'(0)};
                    end else begin
                        lim_f_reg <= lim_f_reg + {prod_reg[LIMS_W-HALF_W-1:0], HALF_W'(0)};
                    end
                end
            endcase
            ph_reg <= phase_t'(ph_reg + 1'b1);
            if (ph_reg == PH_ACC) begin
                grp_reg <= group_t'(grp_reg + 1'b1);
            end
        end

        if (out_load) begin
            m_pt_reg <= rd_pt;
            if (main_pend_reg) begin
                m_cls_reg  <= cls_main;
                m_last_reg <= (k_reg == '0) && last_reg;
            end else begin
                m_cls_reg  <= cls_flush;
                m_last_reg <= (j_reg == '0);
                if (j_reg != '0) begin
                    j_reg <= j_reg - 1'b1;
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(m_pt_reg);
    assign m_tuser  = m_cls_reg;
    assign m_tlast  = m_last_reg;

endmodule

[bench/point_curvature_classifier_tb.sv]
// testbench for the point curvature classifier: directed table, random scans, scoreboard
`timescale 1ns / 1ps

module point_curvature_classifier_tb;
    import pcc_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 64;     // a little above the worst per-point latency
    localparam int QUIET_LIMIT   = 4000;   // cycles with no request moving on any channel
    localparam int HOLD_CYCLES   = 400;    // long receiver hold-off, enough to back up the input
    localparam int RANDOM_POINTS = 225;
    localparam int MAX_REPORTS   = 40;
    localparam int IDLE_PCT      = 28;
    localparam logic [LIM_W-1:0] LIMIT_MAX = {LIM_W{1'b1}};

    typedef enum logic [0:0] {
        ROW_REG,
        ROW_POINT
    } row_kind_t;

    // one line of the directed table; typed rows carry their own expected class
    typedef struct {
        row_kind_t        kind;
        cfg_reg_t         reg_idx;
        logic [LIM_W-1:0] reg_val;
        point_t           pt;
        logic             last;
        logic             typed;
        class_t           cls;
    } stim_row_t;

    typedef struct {
        point_t pt;
        class_t cls;
        logic   fin;
    } class_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LIM_W-1:0]     cfg_data;

    // predictor state: its own copy of the window, scan count and registers
    point_t           window_pts [WIN_DEPTH];
    int unsigned      scan_count;
    logic [K_W-1:0]   nbr_cfg;
    logic [LIM_W-1:0] edge_cfg;
    logic [LIM_W-1:0] flat_cfg;

    class_result_t step_results[$];      // results of the latest point
    class_result_t pending_results[$];   // expected, oldest first
    stim_row_t     directed_rows[$];

    // random scan shape
    logic [31:0] base_c [3];
    logic [31:0] step_c [3];
    int          noise_mode;

    // bookkeeping
    int  mismatches;
    int  points_in;
    int  results_out;
    int  scans_done;
    int  settings_used;
    int  quiet_cycles;
    int  class_seen [4];
    bit  steady;        // no idling on either side while set
    bit  hold_req;      // asks the receiver for one long hold-off

    point_curvature_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [19:0] pos_x, [39:20] pos_y, [59:40] pos_z
        .s_tlast   (s_tlast),    // scan_end
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [19:0] out_x, [39:20] out_y, [59:40] out_z
        .m_tuser   (m_tuser),    // [1:0] point_class
        .m_tlast   (m_tlast),    // final_of_scan
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ------------------------------------------------------------------
    // curvature predictor
    // ------------------------------------------------------------------

    function automatic longint coord_of(point_t p, int a);
        case (a)
            0:       return longint'($signed(p.x));
            1:       return longint'($signed(p.y));
            default: return longint'($signed(p.z));
        endcase
    endfunction

    // exact compare against the limits scaled by 4K^2, no division
    function automatic class_t grade(longint unsigned score, int unsigned k);
        longint unsigned scale;
        scale = 4 * k * k;
        if (score >= 64'(edge_cfg) * scale) begin
            return CLS_EDGE;
        end
        if (score <= 64'(flat_cfg) * scale) begin
            return CLS_FLAT;
        end
        return CLS_NEITHER;
    endfunction

    // shift the point in and list the classified points it releases
    function automatic void classify_point(point_t p, logic last);
        int unsigned     k;
        int unsigned     n;
        int              top;
        int              i;
        int              a;
        longint          sum;
        longint          ctr;
        longint          d;
        longint unsigned score;
        step_results = {};
        k = (nbr_cfg > MAX_NEIGHBORS) ? MAX_NEIGHBORS : nbr_cfg;
        n = scan_count;
        for (i = WIN_DEPTH - 1; i > 0; i--) begin
            window_pts[i] = window_pts[i-1];
        end
        window_pts[0] = p;
        if (k == 0) begin
            step_results.insert(step_results.size(), '{window_pts[0], CLS_NEITHER, last});
        end else begin
            if (n >= k) begin
                score = 0;
                // full neighbourhood only once 2K earlier points of this scan exist
                if (n >= 2 * k) begin
                    for (a = 0; a < 3; a++) begin
                        sum = 0;
                        for (i = 0; i <= 2 * k; i++) begin
                            sum += coord_of(window_pts[i], a);
                        end
                        ctr = coord_of(window_pts[k], a);
                        d = (sum - ctr) - longint'(2 * k) * ctr;
                        score += longint'(d * d);
                    end
                end
                step_results.insert(step_results.size(),
                                    '{window_pts[k], grade(score, k), 1'b0});
            end
            // scan end flushes the points still short of later neighbours
            if (last) begin
                top = (n < k - 1) ? n : k - 1;
                for (i = top; i >= 0; i--) begin
                    step_results.insert(step_results.size(),
                                        '{window_pts[i], grade(0, k), i == 0});
                end
            end
        end
        if (last) begin
            scan_count = 0;
        end else if (scan_count < 2 * MAX_NEIGHBORS) begin
            scan_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want) begin
            report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                      results_out, name, got, want));
        end
    endtask

    always @(posedge aclk) begin : result_check
        class_result_t want;
        point_t        got_pt;
        if (aresetn && m_tvalid && m_tready) begin
            got_pt = m_tdata[3*COORD_W-1:0];
            results_out++;
            class_seen[m_tuser]++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          results_out));
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                check_field("out_x", coord_of(got_pt, 0), coord_of(want.pt, 0));
                check_field("out_y", coord_of(got_pt, 1), coord_of(want.pt, 1));
                check_field("out_z", coord_of(got_pt, 2), coord_of(want.pt, 2));
                check_field("point_class", m_tuser, want.cls);
                check_field("final_of_scan", m_tlast, want.fin);
            end
        end
    end

    // stall watchdog: ends the run when no request moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles, %0d results pending",
                         QUIET_LIMIT, pending_results.size());
                $display("tb: failure");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: random back-pressure plus one long hold-off
    // ------------------------------------------------------------------

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // one point request; expectations are queued at the accepting edge
    task automatic send_point(point_t p, logic last, logic typed, class_t cls);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W - 3 * COORD_W){1'b0}}, p};
        s_tlast  <= last;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        points_in++;
        if (last) begin
            scans_done++;
        end
        classify_point(p, last);
        if (typed) begin
            pending_results.insert(pending_results.size(), '{p, cls, last});
        end else begin
            foreach (step_results[i]) begin
                pending_results.insert(pending_results.size(), step_results[i]);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [LIM_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        case (idx)
            REG_NEIGHBOR_COUNT: nbr_cfg  = val[K_W-1:0];
            REG_EDGE_LIMIT:     edge_cfg = val;
            REG_FLAT_LIMIT:     flat_cfg = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // registers change only with nothing in flight
    task automatic wait_idle();
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic stim_row_t reg_row(cfg_reg_t idx, logic [LIM_W-1:0] val);
        stim_row_t r;
        r = '{ROW_REG, idx, val, '0, 1'b0, 1'b0, CLS_NEITHER};
        return r;
    endfunction

    function automatic stim_row_t pt_row(int x, int y, int z, logic last,
                                         logic typed, class_t cls);
        stim_row_t r;
        point_t    p;
        p.x = x[COORD_W-1:0];
        p.y = y[COORD_W-1:0];
        p.z = z[COORD_W-1:0];
        r = '{ROW_POINT, REG_NEIGHBOR_COUNT, '0, p, last, typed, cls};
        return r;
    endfunction

    // appends one line to the directed table
    function automatic void add_row(stim_row_t r);
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    // random point of the current scan: a line with jitter, spikes, or pure noise
    function automatic point_t scan_point(int idx);
        point_t      p;
        logic [31:0] v [3];
        int          a;
        for (a = 0; a < 3; a++) begin
            if (noise_mode == 2) begin
                v[a] = $urandom;
            end else begin
                v[a] = base_c[a] + idx * step_c[a];
                if (noise_mode == 0) begin
                    v[a] += $urandom_range(16) - 8;
                end else begin
                    v[a] += $urandom_range(400) - 200;
                end
                if ($urandom_range(99) < 8) begin
                    v[a] += $urandom_range(4000) - 2000;
                end
            end
        end
        p.x = v[0][COORD_W-1:0];
        p.y = v[1][COORD_W-1:0];
        p.z = v[2][COORD_W-1:0];
        return p;
    endfunction

    // new neighbour count and, most of the time, new limits
    task automatic pick_setting();
        int               r;
        logic [K_W-1:0]   k;
        logic [LIM_W-1:0] e;
        logic [LIM_W-1:0] f;
        r = $urandom_range(99);
        if (r < 10) begin
            k = 0;
        end else if (r < 22) begin
            k = MAX_NEIGHBORS;
        end else if (r < 30) begin
            k = $urandom_range(15, MAX_NEIGHBORS + 1);   // saturates
        end else begin
            k = $urandom_range(MAX_NEIGHBORS - 1, 1);
        end
        r = $urandom_range(99);
        if (r < 10) begin
            e = '0;
            f = '0;
        end else if (r < 16) begin
            e = LIMIT_MAX;
            f = LIMIT_MAX;
        end else if (r < 24) begin
            e = LIMIT_MAX;
            f = {$urandom, $urandom};
        end else begin
            f = $urandom_range(3000);
            e = f + $urandom_range(80000, 1);
        end
        wait_idle();
        settings_used++;
        write_reg(REG_NEIGHBOR_COUNT, LIM_W'(k));
        if ($urandom_range(9) < 7) begin
            write_reg(REG_EDGE_LIMIT, e);
        end
        if ($urandom_range(9) < 7) begin
            write_reg(REG_FLAT_LIMIT, f);
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin : main
        int          i;
        int          a;
        int          nscans;
        int          len;
        int unsigned k;
        int          random_sent;
        int          hold_at;
        int          pause_at;
        int          steady_lo;
        stim_row_t   row;

        aclk      = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_NEIGHBOR_COUNT;
        cfg_data  = '0;
        steady    = 1'b0;
        hold_req  = 1'b0;
        mismatches    = 0;
        points_in     = 0;
        results_out   = 0;
        scans_done    = 0;
        settings_used = 0;
        quiet_cycles  = 0;
        foreach (class_seen[j]) class_seen[j] = 0;

        // register defaults and an empty scan, as after reset
        nbr_cfg    = 4'd5;
        edge_cfg   = 40'd52429;
        flat_cfg   = 40'd5243;
        scan_count = 0;
        foreach (window_pts[j]) window_pts[j] = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        // zero neighbours first: every point leaves at once as neither, and
        // seventeen of them fill the whole window before any wider read
        add_row(reg_row(REG_NEIGHBOR_COUNT, 0));
        add_row(pt_row(-524288, -524288, -524288, 0, 1, CLS_NEITHER));
        add_row(pt_row(524287, 524287, 524287, 0, 1, CLS_NEITHER));
        add_row(pt_row(0, 0, 0, 1, 1, CLS_NEITHER));
        add_row(pt_row(349525, -349526, 1, 0, 1, CLS_NEITHER));
        add_row(pt_row(-349526, 349525, -1, 0, 1, CLS_NEITHER));
        add_row(pt_row(1, -1, 0, 1, 1, CLS_NEITHER));
        for (i = 0; i < 11; i++) begin
            add_row(pt_row(100 * i, -50 * i, 7, i == 10, 1, CLS_NEITHER));
        end
        // neighbour count above the maximum, short scan: all flushed, missing neighbours
        add_row(reg_row(REG_NEIGHBOR_COUNT, 15));
        add_row(pt_row(1000, 2000, 3000, 0, 0, CLS_NEITHER));
        add_row(pt_row(1010, 2000, 3000, 0, 0, CLS_NEITHER));
        add_row(pt_row(1020, 2000, 3000, 1, 0, CLS_NEITHER));
        // edge limit zero: even a zero score is edge
        add_row(reg_row(REG_EDGE_LIMIT, 0));
        add_row(reg_row(REG_NEIGHBOR_COUNT, 1));
        add_row(pt_row(0, 0, 0, 0, 0, CLS_NEITHER));
        add_row(pt_row(0, 0, 0, 0, 0, CLS_NEITHER));
        add_row(pt_row(40, 0, 0, 0, 0, CLS_NEITHER));
        add_row(pt_row(0, 0, 0, 1, 0, CLS_NEITHER));
        // both limits at their maximum, coordinates swinging end to end
        add_row(reg_row(REG_EDGE_LIMIT, LIMIT_MAX));
        add_row(reg_row(REG_FLAT_LIMIT, LIMIT_MAX));
        add_row(pt_row(-524288, -524288, -524288, 0, 0, CLS_NEITHER));
        add_row(pt_row(524287, 524287, 524287, 0, 0, CLS_NEITHER));
        add_row(pt_row(-524288, -524288, -524288, 1, 0, CLS_NEITHER));

        foreach (directed_rows[j]) begin
            row = directed_rows[j];
            if (row.kind == ROW_REG) begin
                wait_idle();
                settings_used++;
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_point(row.pt, row.last, row.typed, row.cls);
            end
        end

        // random scans under random settings; configuration only between scans
        random_sent = 0;
        hold_at     = $urandom_range(70, 30);
        pause_at    = $urandom_range(130, 100);
        steady_lo   = $urandom_range(180, 150);
        while (random_sent < RANDOM_POINTS) begin
            pick_setting();
            k = (nbr_cfg > MAX_NEIGHBORS) ? MAX_NEIGHBORS : nbr_cfg;
            nscans = $urandom_range(3, 1);
            repeat (nscans) begin
                // mostly scans long enough for full neighbourhoods, some cut short
                if ($urandom_range(99) < 70) begin
                    len = $urandom_range(2 * k + 12, 2 * k + 1);
                end else begin
                    len = $urandom_range(2 * k + 1, 1);
                end
                for (a = 0; a < 3; a++) begin
                    base_c[a] = $urandom;
                    step_c[a] = $urandom_range(128) - 64;
                end
                a = $urandom_range(99);
                noise_mode = (a < 50) ? 0 : (a < 85) ? 1 : 2;
                for (i = 0; i < len; i++) begin
                    if (random_sent == hold_at) begin
                        hold_req = 1'b1;
                    end
                    if (random_sent == pause_at) begin
                        // sender goes quiet until every pending result has come
                        while (pending_results.size() != 0) begin
                            @(posedge aclk);
                        end
                    end
                    steady = (random_sent >= steady_lo) && (random_sent < steady_lo + 50);
                    send_point(scan_point(i), i == len - 1, 1'b0, CLS_NEITHER);
                    random_sent++;
                end
            end
        end
        steady = 1'b0;

        // drain, then give any stray result time to show up
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered: %0d points in %0d scans under %0d register settings",
                 points_in, scans_done, settings_used);
        $display("covered: %0d results, %0d edge, %0d flat, %0d neither; %0d mismatches",
                 results_out, class_seen[CLS_EDGE], class_seen[CLS_FLAT],
                 class_seen[CLS_NEITHER], mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
